### design/sgdd_pkg.sv
// Shared types and constants for the signed gadget digit decomposition unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sgdd_pkg;

  localparam int unsigned CoeffW    = 32;
  localparam int unsigned ModW      = CoeffW + 1;
  localparam int unsigned BaseW     = 6;
  localparam int unsigned CountW    = 6;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned OutDataW  = 40;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_BASE_BITS   = 2'd1,
    CFG_DIGIT_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CoeffW-1:0] modulus;
    logic [BaseW-1:0]  base_bits;
    logic [CountW-1:0] digit_count;
  } cfg_t;

  typedef struct packed {
    logic [CoeffW-1:0] mag;
    logic              negative;
    logic              last_coeff;
  } work_t;

  function automatic logic [ModW-1:0] eff_modulus(logic [CoeffW-1:0] m);
    logic [ModW-1:0] q;
    q = (m == '0) ? {1'b1, {CoeffW{1'b0}}} : {1'b0, m};
    return q;
  endfunction

endpackage

`default_nettype wire

### design/sgdd_front.sv
// Front end: accept coefficients, pick the sign and compute the magnitude.
// Depends on sgdd_pkg; feeds sgdd_fifo.
`default_nettype none

module sgdd_front import sgdd_pkg::*; (
  input  wire logic              s_valid_i,
  output      logic              s_ready_o,
  input  wire logic [CoeffW-1:0] s_coeff_i,
  input  wire logic              s_last_i,
  input  wire cfg_t              cfg_i,
  output      logic              push_valid_o,
  input  wire logic              push_ready_i,
  output      work_t             push_data_o
);

  logic [ModW-1:0] q;
  logic [ModW-1:0] c_ext;
  logic [ModW-1:0] diff;

  always_comb begin
    q     = eff_modulus(cfg_i.modulus);
    c_ext = {1'b0, s_coeff_i};
    diff  = (c_ext >= q) ? (c_ext - q) : (q - c_ext);
    push_data_o.negative   = c_ext > (q >> 1);
    push_data_o.mag        = push_data_o.negative ? diff[CoeffW-1:0] : s_coeff_i;
    push_data_o.last_coeff = s_last_i;
  end

  assign push_valid_o = s_valid_i;
  assign s_ready_o    = push_ready_i;

endmodule

`default_nettype wire

### design/sgdd_fifo.sv
// Two-slot queue between front and back ends, head always in slot 0.
// Depends on sgdd_pkg for the work_t entry type.
`default_nettype none

module sgdd_fifo import sgdd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output      logic  push_ready_o,
  input  wire work_t push_data_i,
  output      logic  pop_valid_o,
  input  wire logic  pop_ready_i,
  output      work_t pop_data_o
);

  logic  v0_q, v0_d, v1_q, v1_d;
  work_t s0_q, s0_d, s1_q, s1_d;
  logic  push, pop;

  assign push_ready_o = !v1_q;
  assign pop_valid_o  = v0_q;
  assign pop_data_o   = s0_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = v0_q && pop_ready_i;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    s0_d = s0_q;
    s1_d = s1_q;
    if (pop) begin
      if (v1_q) begin
        s0_d = s1_q;
        if (push) begin
          s1_d = push_data_i;
        end else begin
          v1_d = 1'b0;
        end
      end else if (push) begin
        s0_d = push_data_i;
      end else begin
        v0_d = 1'b0;
      end
    end else if (push) begin
      if (!v0_q) begin
        s0_d = push_data_i;
        v0_d = 1'b1;
      end else begin
        s1_d = push_data_i;
        v1_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule

`default_nettype wire

### design/sgdd_rem.sv
// Bit-serial remainder unit, one dividend bit per cycle (restoring).
// Depends on sgdd_pkg; used by sgdd_back for digits not below the modulus.
`default_nettype none

module sgdd_rem import sgdd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CoeffW-1:0] dividend_i,
  input  wire logic [ModW-1:0]   divisor_i,
  input  wire logic              clear_i,
  output      logic              busy_o,
  output      logic              valid_o,
  output      logic [CoeffW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(CoeffW);

  logic              busy_q, valid_q;
  logic [CntW-1:0]   cnt_q;
  logic [ModW-1:0]   acc_q;
  logic [CoeffW-1:0] dvd_q;
  logic [ModW-1:0]   div_q;
  logic [ModW:0]     trial;
  logic [ModW:0]     diff;
  logic [ModW-1:0]   acc_d;

  always_comb begin
    trial = {acc_q, dvd_q[CoeffW-1]};
    diff  = trial - {1'b0, div_q};
    acc_d = (trial >= {1'b0, div_q}) ? diff[ModW-1:0] : trial[ModW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      valid_q <= 1'b0;
      cnt_q   <= CntW'(CoeffW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q  <= 1'b0;
        valid_q <= 1'b1;
      end
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      dvd_q <= {dvd_q[CoeffW-2:0], 1'b0};
    end
  end

  assign busy_o  = busy_q;
  assign valid_o = valid_q;
  assign rem_o   = acc_q[CoeffW-1:0];

endmodule

`default_nettype wire

### design/sgdd_back.sv
// Back end: split each magnitude into digits, apply the sign, register results.
// Depends on sgdd_pkg and sgdd_rem.
`default_nettype none

module sgdd_back import sgdd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              q_valid_i,
  output      logic              q_ready_o,
  input  wire work_t             q_data_i,
  output      logic              m_valid_o,
  input  wire logic              m_ready_i,
  output      logic [CoeffW-1:0] m_value_o,
  output      logic [IdxW-1:0]   m_index_o,
  output      logic              m_last_o,
  output      logic              m_end_o
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);

  logic              busy_q;
  logic [CoeffW-1:0] mag_q;
  logic              neg_q, lastc_q;
  logic [CntW-1:0]   k_q;
  logic              out_valid_q;
  logic [CoeffW-1:0] out_value_q;
  logic [IdxW-1:0]   out_index_q;
  logic              out_last_q, out_end_q;

  logic [ModW-1:0]      q;
  logic [CountW-1:0]    eff_count;
  logic [CntW-1:0]      k_last;
  logic [CoeffW-1:0]    mask, digit, mag_next, r, value;
  logic [ModW-1:0]      neg_val;
  logic [CntW+IdxW-1:0] k_ext;
  logic                 need_rem, r_ok, out_free, emit, is_last;
  logic                 rem_start, rem_busy, rem_valid;
  logic [CoeffW-1:0]    rem_val;

  always_comb begin
    q = eff_modulus(cfg_i.modulus);
    if (cfg_i.digit_count == '0) begin
      eff_count = CountW'(1);
    end else if (int'(cfg_i.digit_count) > int'(MAX_DIGITS)) begin
      eff_count = CountW'(MAX_DIGITS);
    end else begin
      eff_count = cfg_i.digit_count;
    end
    k_last = CntW'(eff_count - 1'b1);

    if (cfg_i.base_bits[BaseW-1]) begin
      mask     = '1;
      mag_next = '0;
    end else begin
      mask     = (CoeffW'(1) << cfg_i.base_bits[BaseW-2:0]) - 1'b1;
      mag_next = mag_q >> cfg_i.base_bits[BaseW-2:0];
    end
    if (cfg_i.base_bits == '0) begin
      mask = '0;
    end

    digit     = mag_q & mask;
    need_rem  = {1'b0, digit} >= q;
    r_ok      = !need_rem || rem_valid;
    r         = need_rem ? rem_val : digit;
    neg_val   = q - {1'b0, r};
    value     = (neg_q && (r != '0)) ? neg_val[CoeffW-1:0] : r;
    out_free  = !out_valid_q || m_ready_i;
    emit      = busy_q && r_ok && out_free;
    is_last   = k_q == k_last;
    rem_start = busy_q && need_rem && !rem_busy && !rem_valid;
    k_ext     = {{IdxW{1'b0}}, k_q};
  end

  assign q_ready_o = !busy_q || (emit && is_last);

  sgdd_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (digit),
    .divisor_i  (q),
    .clear_i    (emit && need_rem),
    .busy_o     (rem_busy),
    .valid_o    (rem_valid),
    .rem_o      (rem_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_valid_i && q_ready_o) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (emit) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      mag_q   <= q_data_i.mag;
      neg_q   <= q_data_i.negative;
      lastc_q <= q_data_i.last_coeff;
    end else if (emit) begin
      mag_q <= mag_next;
    end
    if (emit) begin
      out_value_q <= value;
      out_index_q <= k_ext[IdxW-1:0];
      out_last_q  <= is_last;
      out_end_q   <= is_last && lastc_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_value_o = out_value_q;
  assign m_index_o = out_index_q;
  assign m_last_o  = out_last_q;
  assign m_end_o   = out_end_q;

endmodule

`default_nettype wire

### design/signed_gadget_digit_decomposition_unit.sv
// Top level of the signed gadget digit decomposition unit: configuration
// registers, front end, queue and back end. Depends on sgdd_pkg and submodules.
//
// Usage:
//   s_axis carries one coefficient per transfer, tlast marks the last one of
//   a polynomial. m_axis carries one digit per transfer, least significant
//   first; tlast marks the final digit of a coefficient and tuser the final
//   digit of the polynomial. The cfg channel writes modulus (index 0),
//   base_bits (index 1) and digit_count (index 2); it is always ready and
//   must only be used while the block is idle.
//   A coefficient passes the queue and the back-end work registers; its first
//   digit is then registered in the output register. Throughput: one digit per
//   cycle while m_axis does not stall, and a coefficient gives digit_count digits
//   (at least one, at most MAX_DIGITS). A digit not below the modulus, which only
//   arises from a coefficient not below the modulus, stalls the output until the bit-serial remainder unit is done.
//   Reset loads modulus 2^32-1, base_bits 8, digit_count 4 and empties the
//   queue and output register. When m_axis stalls, the output register holds,
//   the two-entry queue keeps accepting and then s_axis_tready drops.
`default_nettype none

module signed_gadget_digit_decomposition_unit import sgdd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [CoeffW-1:0]   s_axis_tdata_i,   // [31:0] coefficient
  input  wire logic                s_axis_tlast_i,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic [OutDataW-1:0] m_axis_tdata_o,   // [31:0] digit_value, [36:32] digit_index
  output      logic                m_axis_tlast_o,
  output      logic                m_axis_tuser_o,   // [0] polynomial_end
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  work_t             push_data, pop_data;
  logic [CoeffW-1:0] value;
  logic [IdxW-1:0]   index;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus     <= '1;
      cfg_q.base_bits   <= BaseW'(8);
      cfg_q.digit_count <= CountW'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MODULUS:     cfg_q.modulus     <= cfg_data_i[CoeffW-1:0];
        CFG_BASE_BITS:   cfg_q.base_bits   <= cfg_data_i[BaseW-1:0];
        CFG_DIGIT_COUNT: cfg_q.digit_count <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  sgdd_front u_front (
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_coeff_i    (s_axis_tdata_i),
    .s_last_i     (s_axis_tlast_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  sgdd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  sgdd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (pop_valid),
    .q_ready_o (pop_ready),
    .q_data_i  (pop_data),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_value_o (value),
    .m_index_o (index),
    .m_last_o  (m_axis_tlast_o),
    .m_end_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(OutDataW - CoeffW - IdxW){1'b0}}, index, value};

endmodule

`default_nettype wire

### design/sgdd_checker.sv
// Port-level checks for the signed gadget digit decomposition unit.
// Depends on sgdd_pkg; bound to the top level below.
`default_nettype none

module sgdd_checker import sgdd_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid_i,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_i,
  input wire logic                m_axis_tlast_i,
  input wire logic                m_axis_tuser_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))
    else $error("stalled digit changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i |-> m_axis_tlast_i)
    else $error("polynomial end without last digit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[OutDataW-1:CoeffW+IdxW] == '0)
    else $error("tdata padding not zero");

  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_i)
    else $error("output valid right after reset");

endmodule

bind signed_gadget_digit_decomposition_unit sgdd_checker u_sgdd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
